>>> sv/bq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad filter package
// Shared types, register indexes, saturation helpers and the control store
// of the biquad sequencer.
// ----------------------------------------------------------------------------
package bq_pkg;

  localparam int COEF_W     = 32;
  localparam int ACC_W      = 64;
  localparam int HIST_Y_W   = 32;
  localparam int TDF2_W     = 48;
  localparam int PC_W       = 5;
  localparam int MIX_SHIFT  = 15;

  localparam logic [15:0] WEIGHT_ONE = 16'd32768;
  localparam logic signed [ACC_W-1:0] HALF_MIX = 64'sd16384;

  localparam logic [2:0] REG_B0     = 3'd0;
  localparam logic [2:0] REG_B1     = 3'd1;
  localparam logic [2:0] REG_B2     = 3'd2;
  localparam logic [2:0] REG_A1     = 3'd3;
  localparam logic [2:0] REG_A2     = 3'd4;
  localparam logic [2:0] REG_WEIGHT = 3'd5;
  localparam logic [2:0] REG_MODE   = 3'd6;

  localparam logic [1:0] MODE_DF1   = 2'd0;
  localparam logic [1:0] MODE_BLEND = 2'd1;
  localparam logic [1:0] MODE_TDF2  = 2'd2;

  localparam logic [PC_W-1:0] DF1_ENTRY  = 5'd0;
  localparam logic [PC_W-1:0] TDF2_ENTRY = 5'd13;

  typedef enum logic [2:0] {
    MA_B0, MA_B1, MA_B2, MA_A1, MA_A2, MA_W, MA_WC
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_X, MB_X1, MB_X2, MB_Y1, MB_Y2, MB_Y32
  } mul_b_t;

  typedef enum logic [2:0] {
    AO_HOLD, AO_LOAD_P, AO_ADD_P, AO_SUB_P, AO_ADD_S1, AO_ADD_S2, AO_ADD_HF, AO_ADD_HM
  } acc_op_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_Y, WR_Y_HIST, WR_MIX, WR_S1, WR_S2
  } wr_t;

  typedef enum logic [1:0] {
    NX_STEP, NX_END_UNLESS_BLEND, NX_END
  } nxt_t;

  typedef struct packed {
    mul_a_t  ma;
    mul_b_t  mb;
    acc_op_t op;
    wr_t     wr;
    nxt_t    nx;
  } ucode_t;

  typedef struct packed {
    logic   fire;
    ucode_t uc;
  } bq_ctrl_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic        [15:0]       weight;
    logic        [1:0]        mode;
  } bq_cfg_t;

  function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = 65'(a) + 65'(b);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [HIST_Y_W-1:0] clamp32(input logic signed [ACC_W-1:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[HIST_Y_W-1:0];
  endfunction

  function automatic logic signed [TDF2_W-1:0] clamp48(input logic signed [ACC_W-1:0] v);
    if (v > 64'sd140737488355327) begin
      return 48'h7FFF_FFFF_FFFF;
    end
    if (v < -64'sd140737488355328) begin
      return 48'h8000_0000_0000;
    end
    return v[TDF2_W-1:0];
  endfunction

  // Direct form 1 runs from DF1_ENTRY, the crossfade continues after its
  // history update, and transposed form 2 runs from TDF2_ENTRY.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      5'd0:  w = '{MA_B0, MB_X,   AO_HOLD,   WR_NONE,   NX_STEP};
      5'd1:  w = '{MA_B1, MB_X1,  AO_LOAD_P, WR_NONE,   NX_STEP};
      5'd2:  w = '{MA_B2, MB_X2,  AO_ADD_P,  WR_NONE,   NX_STEP};
      5'd3:  w = '{MA_A1, MB_Y1,  AO_ADD_P,  WR_NONE,   NX_STEP};
      5'd4:  w = '{MA_A2, MB_Y2,  AO_SUB_P,  WR_NONE,   NX_STEP};
      5'd5:  w = '{MA_B0, MB_X,   AO_SUB_P,  WR_NONE,   NX_STEP};
      5'd6:  w = '{MA_B0, MB_X,   AO_ADD_HF, WR_NONE,   NX_STEP};
      5'd7:  w = '{MA_B0, MB_X,   AO_HOLD,   WR_Y_HIST, NX_END_UNLESS_BLEND};
      5'd8:  w = '{MA_W,  MB_Y32, AO_HOLD,   WR_NONE,   NX_STEP};
      5'd9:  w = '{MA_WC, MB_X,   AO_LOAD_P, WR_NONE,   NX_STEP};
      5'd10: w = '{MA_B0, MB_X,   AO_ADD_P,  WR_NONE,   NX_STEP};
      5'd11: w = '{MA_B0, MB_X,   AO_ADD_HM, WR_NONE,   NX_STEP};
      5'd12: w = '{MA_B0, MB_X,   AO_HOLD,   WR_MIX,    NX_END};
      5'd13: w = '{MA_B0, MB_X,   AO_HOLD,   WR_NONE,   NX_STEP};
      5'd14: w = '{MA_B0, MB_X,   AO_LOAD_P, WR_NONE,   NX_STEP};
      5'd15: w = '{MA_B0, MB_X,   AO_ADD_S1, WR_NONE,   NX_STEP};
      5'd16: w = '{MA_B0, MB_X,   AO_ADD_HF, WR_NONE,   NX_STEP};
      5'd17: w = '{MA_B1, MB_X,   AO_HOLD,   WR_Y,      NX_STEP};
      5'd18: w = '{MA_A1, MB_Y32, AO_LOAD_P, WR_NONE,   NX_STEP};
      5'd19: w = '{MA_B0, MB_X,   AO_SUB_P,  WR_NONE,   NX_STEP};
      5'd20: w = '{MA_B0, MB_X,   AO_ADD_S2, WR_NONE,   NX_STEP};
      5'd21: w = '{MA_B2, MB_X,   AO_HOLD,   WR_S1,     NX_STEP};
      5'd22: w = '{MA_A2, MB_Y32, AO_LOAD_P, WR_NONE,   NX_STEP};
      5'd23: w = '{MA_B0, MB_X,   AO_SUB_P,  WR_NONE,   NX_STEP};
      5'd24: w = '{MA_B0, MB_X,   AO_HOLD,   WR_S2,     NX_END};
      default: w = '{MA_B0, MB_X, AO_HOLD,   WR_NONE,   NX_END};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> sv/biquad_iir_filter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad IIR filter core
// Second-order filter in direct form 1, crossfaded direct form 1 or
// transposed direct form 2, on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Each item runs through the 8, 13 or 12 steps of the program in direct form 1,
// the crossfade mode or transposed form 2 on the single multiplier and
// accumulator, then waits in a hand-over state; a stalled output holds the
// block in hand-over. A new item is taken only in the idle or hand-over state.
// Reset clears the history and loads unity gain, full weight and direct form 1.

module biquad_iir_filter_core import bq_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 28
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // sample_in
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,
  // clear_history
  input  wire logic [0:0]                           s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // sample_out
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         m_tdata,
  // clipped
  output logic [0:0]                                m_tuser,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [2:0]                           cfg_index,
  input  wire logic [31:0]                          cfg_wdata
);

  localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int Y_W    = ACC_W - COEF_FRAC_BITS;
  localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  bq_cfg_t                  cfg;
  bq_ctrl_t                 ctrl;
  logic                     accept, emit, out_free;
  logic signed [Y_W-1:0]    y;
  logic [SAMPLE_WIDTH-1:0]  y_clamped;
  logic                     y_clip;
  logic [SAMPLE_WIDTH-1:0]  out_sample;
  logic                     out_clip;

  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = DATA_W'(out_sample);
  assign m_tuser  = out_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.b0     <= COEF_W'(64'd1 << COEF_FRAC_BITS);
      cfg.b1     <= '0;
      cfg.b2     <= '0;
      cfg.a1     <= '0;
      cfg.a2     <= '0;
      cfg.weight <= WEIGHT_ONE;
      cfg.mode   <= MODE_DF1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_B0:     cfg.b0     <= cfg_wdata;
        REG_B1:     cfg.b1     <= cfg_wdata;
        REG_B2:     cfg.b2     <= cfg_wdata;
        REG_A1:     cfg.a1     <= cfg_wdata;
        REG_A2:     cfg.a2     <= cfg_wdata;
        REG_WEIGHT: cfg.weight <= cfg_wdata[15:0];
        REG_MODE:   cfg.mode   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  bq_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .tdf2     (cfg.mode == MODE_TDF2),
    .blend    (cfg.mode == MODE_BLEND),
    .out_free (out_free),
    .ctrl     (ctrl),
    .ready    (s_tready),
    .emit     (emit)
  );

  bq_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .clear  (s_tuser[0]),
    .sample (s_tdata[SAMPLE_WIDTH-1:0]),
    .cfg    (cfg),
    .ctrl   (ctrl),
    .y      (y)
  );

  always_comb begin
    if ((&y[Y_W-1:SAMPLE_WIDTH-1]) || !(|y[Y_W-1:SAMPLE_WIDTH-1])) begin
      y_clamped = y[SAMPLE_WIDTH-1:0];
      y_clip    = 1'b0;
    end else begin
      y_clamped = y[Y_W-1] ? SMIN : SMAX;
      y_clip    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample <= y_clamped;
      out_clip   <= y_clip;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again while an item is being filtered");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      (m_tdata[SAMPLE_WIDTH-1:0] == SMAX) || (m_tdata[SAMPLE_WIDTH-1:0] == SMIN))
    else $error("clipped item does not sit at a range limit");

  a_result_from_handover: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tready))
    else $error("result loaded outside the hand-over state");

endmodule
`default_nettype wire

>>> sv/bq_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad sequencer
// Step counter over the control store, with mode dispatch, an early end for
// plain direct form 1 and a hand-over state towards the output register.
// ----------------------------------------------------------------------------
module bq_sequencer import bq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic tdf2,
  input  wire logic blend,
  input  wire logic out_free,
  output bq_ctrl_t  ctrl,
  output logic      ready,
  output logic      emit
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HAND} state_t;

  state_t          state;
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] entry;
  ucode_t          uc;

  always_comb begin
    uc        = ucode_rom(pc);
    entry     = tdf2 ? TDF2_ENTRY : DF1_ENTRY;
    ready     = (state == ST_IDLE) || ((state == ST_HAND) && out_free);
    emit      = (state == ST_HAND) && out_free;
    ctrl.fire = (state == ST_RUN);
    ctrl.uc   = uc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= DF1_ENTRY;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            pc    <= entry;
          end
        end
        ST_RUN: begin
          unique case (uc.nx)
            NX_STEP: begin
              pc <= pc + PC_W'(1);
            end
            NX_END_UNLESS_BLEND: begin
              if (blend) begin
                pc <= pc + PC_W'(1);
              end else begin
                state <= ST_HAND;
              end
            end
            default: begin
              state <= ST_HAND;
            end
          endcase
        end
        ST_HAND: begin
          if (out_free) begin
            if (start) begin
              state <= ST_RUN;
              pc    <= entry;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/bq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad datapath
// One shared 32 by 32 multiplier with a product register, a saturating 64-bit
// accumulator and the filter history, all steered by the control word.
// ----------------------------------------------------------------------------
module bq_datapath import bq_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 28
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           load,
  input  wire logic                           clear,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire bq_cfg_t                        cfg,
  input  wire bq_ctrl_t                       ctrl,
  output logic signed [ACC_W-COEF_FRAC_BITS-1:0] y
);

  localparam int Y_W = ACC_W - COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF_F = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));

  logic signed [SAMPLE_WIDTH-1:0] x, x1, x2;
  logic signed [HIST_Y_W-1:0]     y1, y2, y32;
  logic signed [TDF2_W-1:0]       s1, s2;
  logic signed [ACC_W-1:0]        prod, acc;

  logic        [15:0]             w_eff, w_cmp;
  logic signed [COEF_W-1:0]       op_a, op_b;
  logic signed [ACC_W-1:0]        base, addend, acc_next, shr_f, shr_mix;
  logic signed [HIST_Y_W-1:0]     y_sat;

  always_comb begin
    w_eff = (cfg.weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.weight;
    w_cmp = WEIGHT_ONE - w_eff;

    unique case (ctrl.uc.ma)
      MA_B1:   op_a = cfg.b1;
      MA_B2:   op_a = cfg.b2;
      MA_A1:   op_a = cfg.a1;
      MA_A2:   op_a = cfg.a2;
      MA_W:    op_a = {16'd0, w_eff};
      MA_WC:   op_a = {16'd0, w_cmp};
      default: op_a = cfg.b0;
    endcase

    unique case (ctrl.uc.mb)
      MB_X1:   op_b = COEF_W'(x1);
      MB_X2:   op_b = COEF_W'(x2);
      MB_Y1:   op_b = y1;
      MB_Y2:   op_b = y2;
      MB_Y32:  op_b = y32;
      default: op_b = COEF_W'(x);
    endcase

    base = acc;
    unique case (ctrl.uc.op)
      AO_LOAD_P: begin
        base   = '0;
        addend = prod;
      end
      AO_ADD_P:  addend = prod;
      AO_SUB_P:  addend = -prod;
      AO_ADD_S1: addend = ACC_W'(s1);
      AO_ADD_S2: addend = ACC_W'(s2);
      AO_ADD_HF: addend = HALF_F;
      AO_ADD_HM: addend = HALF_MIX;
      default:   addend = '0;
    endcase
    acc_next = sat_add64(base, addend);

    shr_f   = acc >>> COEF_FRAC_BITS;
    shr_mix = acc >>> MIX_SHIFT;
    y_sat   = clamp32(shr_f);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
      s1 <= '0;
      s2 <= '0;
    end else if (load && clear) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
      s1 <= '0;
      s2 <= '0;
    end else if (ctrl.fire) begin
      unique case (ctrl.uc.wr)
        WR_Y_HIST: begin
          x2 <= x1;
          x1 <= x;
          y2 <= y1;
          y1 <= y_sat;
        end
        WR_S1:   s1 <= clamp48(acc);
        WR_S2:   s2 <= clamp48(acc);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x <= sample;
    end
    if (ctrl.fire) begin
      prod <= op_a * op_b;
      if (ctrl.uc.op != AO_HOLD) begin
        acc <= acc_next;
      end
      unique case (ctrl.uc.wr)
        WR_Y, WR_Y_HIST: begin
          y   <= shr_f[Y_W-1:0];
          y32 <= y_sat;
        end
        WR_MIX:  y <= shr_mix[Y_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
